// File: src/qubit_state_vector_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the qubit state vector engine
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUBIT_STATE_VECTOR_ENGINE_CORE_DEFINES_SVH
`define QUBIT_STATE_VECTOR_ENGINE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define QSVE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("qsve assertion failed");
`define QSVE_ASSERT_IMPL(lbl, ante, cons) \
	`QSVE_ASSERT(lbl, (ante) |-> (cons))
`else
`define QSVE_ASSERT(lbl, prop)
`define QSVE_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// File: src/qsve_pkg.sv
// ----------------------------------------------------------------------------
// qsve_pkg
// Types and constants shared by the qubit state vector engine.
// ----------------------------------------------------------------------------
package qsve_pkg;

	localparam int MAX_QUBITS = 10;
	localparam int AMP_WIDTH  = 16;
	localparam int AMP_FRAC   = 14;
	localparam int GATE_FRAC  = 14;
	localparam int QC_W       = 4;
	localparam int TQ_W       = 4;
	localparam int PROB_W     = 16;

	localparam int IDX_W      = MAX_QUBITS;
	localparam int BANK_AW    = MAX_QUBITS - 1;
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int AMP_W2     = 2 * AMP_WIDTH;
	localparam int PROD_W     = 2 * AMP_WIDTH;
	localparam int SUM_W      = PROD_W + 2;
	localparam int R_W        = SUM_W - GATE_FRAC;
	localparam int ACC_W      = 2 * AMP_WIDTH + MAX_QUBITS - 1;
	localparam int P_SHIFT    = 2 * AMP_FRAC - PROB_W;
	localparam int P_W        = ACC_W - P_SHIFT;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_GATE = 2'd1,
		OP_MEAS = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		op_t                         operation;
		logic [TQ_W-1:0]             target_qubit;
		logic signed [AMP_WIDTH-1:0] gate_00_re;
		logic signed [AMP_WIDTH-1:0] gate_00_im;
		logic signed [AMP_WIDTH-1:0] gate_01_re;
		logic signed [AMP_WIDTH-1:0] gate_01_im;
		logic signed [AMP_WIDTH-1:0] gate_10_re;
		logic signed [AMP_WIDTH-1:0] gate_10_im;
		logic signed [AMP_WIDTH-1:0] gate_11_re;
		logic signed [AMP_WIDTH-1:0] gate_11_im;
		logic [PROB_W-1:0]           random_fraction;
	} in_word_t;

	typedef struct packed {
		logic              outcome;
		logic [PROB_W-1:0] probability_zero;
		status_t           status;
	} out_word_t;

endpackage

// File: src/qubit_state_vector_engine_core.sv
// ----------------------------------------------------------------------------
// qubit_state_vector_engine_core
// State vector of complex Q2.14 amplitudes with init, single-qubit gate and
// measure operations.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_word) takes one operation word
// at a time; every accepted word yields exactly one result word on the
// output channel (out_valid, out_stall, out_word). The configuration port
// writes qubit_count through cfg_wen and cfg_wdata.
// The amplitudes live in two 512-entry RAM banks selected by the parity of
// the amplitude index, so both members of a gate pair are read and written
// in the same cycle. A gate or measure walks one pair per cycle over all
// pairs of the active qubits, and init sweeps both banks in a single pass.
// An out-of-range target or an unused code returns its result without a
// pass over the banks. After reset the same clearing pass runs and in_stall
// stays high until it ends; configuration writes are taken during it.
// A finished result sits in the output register until it is taken; the
// next word is accepted meanwhile, and its result waits while out_stall
// holds the previous one.
// ----------------------------------------------------------------------------
`include "qubit_state_vector_engine_core_defines.svh"

module qubit_state_vector_engine_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  qsve_pkg::in_word_t             in_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output qsve_pkg::out_word_t            out_word,
	input  logic                           cfg_wen,
	input  logic [qsve_pkg::QC_W-1:0]      cfg_wdata
);

	localparam int AW  = qsve_pkg::AMP_WIDTH;
	localparam int BAW = qsve_pkg::BANK_AW;
	localparam int IW  = qsve_pkg::IDX_W;
	localparam logic signed [qsve_pkg::R_W-1:0] AMP_HI =
		qsve_pkg::R_W'((64'sd1 <<< (AW - 1)) - 64'sd1);
	localparam logic signed [qsve_pkg::R_W-1:0] AMP_LO = -AMP_HI - qsve_pkg::R_W'(1);
	localparam logic [qsve_pkg::AMP_W2-1:0] AMP_ONE =
		{AW'(1) << qsve_pkg::AMP_FRAC, AW'(0)};

	function automatic logic [AW:0] round_sat(input logic signed [qsve_pkg::SUM_W-1:0] sum);
		logic signed [qsve_pkg::SUM_W-1:0] biased;
		logic signed [qsve_pkg::R_W-1:0]   r;
		logic [AW:0]                       res;
		biased = sum + $signed(qsve_pkg::SUM_W'(1) << (qsve_pkg::GATE_FRAC - 1));
		r = qsve_pkg::R_W'(biased >>> qsve_pkg::GATE_FRAC);
		if (r > AMP_HI) begin
			res = {1'b1, AMP_HI[AW-1:0]};
		end else if (r < AMP_LO) begin
			res = {1'b1, AMP_LO[AW-1:0]};
		end else begin
			res = {1'b0, r[AW-1:0]};
		end
		return res;
	endfunction

	qsve_pkg::state_t    state_q, state_d;
	qsve_pkg::in_word_t  item_q;
	qsve_pkg::out_word_t out_word_q, res_word;
	logic [qsve_pkg::QC_W-1:0] qc_q, nq;
	logic [BAW-1:0] cnt_q, cnt_d, last_cnt;
	logic [BAW:0]   pairs;
	logic           boot_q, boot_d;
	logic           out_valid_q, out_load;
	logic           accept, issue, clr_we, in_range;
	logic           sat_q;
	logic [qsve_pkg::ACC_W-1:0] acc_q;

	logic [IW-1:0]  cnt_ext, low_mask, idx_i, idx_j, tq_bit;
	logic           par_i;
	logic [BAW-1:0] ra0, ra1;

	logic           v_s1, v_s2, v_s3;
	logic           swap_s1, swap_s2;
	logic [BAW-1:0] ba0_s1, ba1_s1, ba0_s2, ba1_s2, ba0_s3, ba1_s3;
	logic [qsve_pkg::AMP_W2-1:0] rd0, rd1, amp_a, amp_b, wd0_s3, wd1_s3;
	logic signed [AW-1:0] ar, ai, br, bi;
	logic signed [AW-1:0] g [8];
	logic signed [qsve_pkg::PROD_W-1:0] prod_s2 [16];
	logic [qsve_pkg::PROD_W-1:0] sqr_s2, sqi_s2;
	logic signed [qsve_pkg::SUM_W-1:0] sum_ri, sum_ii, sum_rj, sum_ij;
	logic [AW:0] rs_ri, rs_ii, rs_rj, rs_ij;
	logic [qsve_pkg::AMP_W2-1:0] new_i, new_j;
	logic [qsve_pkg::P_W-1:0] p_val;

	logic           we0, we1;
	logic [BAW-1:0] wa0, wa1;
	logic [qsve_pkg::AMP_W2-1:0] wdat0, wdat1;

	always_comb begin
		if (qc_q == '0) begin
			nq = qsve_pkg::QC_W'(1);
		end else if (qc_q > qsve_pkg::QC_W'(qsve_pkg::MAX_QUBITS)) begin
			nq = qsve_pkg::QC_W'(qsve_pkg::MAX_QUBITS);
		end else begin
			nq = qc_q;
		end
	end

	assign pairs    = (BAW + 1)'(1) << (nq - 1'b1);
	assign last_cnt = BAW'(pairs - 1'b1);
	assign in_range = item_q.target_qubit < nq;

	assign tq_bit   = IW'(1) << item_q.target_qubit;
	assign cnt_ext  = IW'(cnt_q);
	assign low_mask = tq_bit - 1'b1;
	assign idx_i    = ((cnt_ext & ~low_mask) << 1) | (cnt_ext & low_mask);
	assign idx_j    = idx_i | tq_bit;
	assign par_i    = ^idx_i;
	assign ra0      = par_i ? idx_j[IW-1:1] : idx_i[IW-1:1];
	assign ra1      = par_i ? idx_i[IW-1:1] : idx_j[IW-1:1];

	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		boot_d   = boot_q;
		in_stall = 1'b1;
		issue    = 1'b0;
		clr_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			qsve_pkg::S_CLEAR: begin
				clr_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == '1) begin
					boot_d  = 1'b0;
					state_d = boot_q ? qsve_pkg::S_IDLE : qsve_pkg::S_FINISH;
				end
			end
			qsve_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cnt_d = '0;
					unique case (in_word.operation)
						qsve_pkg::OP_INIT: state_d = qsve_pkg::S_CLEAR;
						qsve_pkg::OP_GATE,
						qsve_pkg::OP_MEAS: begin
							state_d = (in_word.target_qubit < nq) ?
								qsve_pkg::S_RUN : qsve_pkg::S_FINISH;
						end
						qsve_pkg::OP_NONE: state_d = qsve_pkg::S_FINISH;
					endcase
				end
			end
			qsve_pkg::S_RUN: begin
				issue = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == last_cnt) begin
					state_d = qsve_pkg::S_DRAIN;
				end
			end
			qsve_pkg::S_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_d = qsve_pkg::S_FINISH;
				end
			end
			qsve_pkg::S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = qsve_pkg::S_IDLE;
				end
			end
			default: state_d = qsve_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qsve_pkg::S_CLEAR;
			cnt_q       <= '0;
			boot_q      <= 1'b1;
			qc_q        <= qsve_pkg::QC_W'(qsve_pkg::MAX_QUBITS);
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			boot_q  <= boot_d;
			if (cfg_wen) begin
				qc_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (item_q.operation == qsve_pkg::OP_GATE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_word;
			sat_q  <= 1'b0;
			acc_q  <= '0;
		end else if (v_s2) begin
			if (item_q.operation == qsve_pkg::OP_GATE) begin
				if (rs_ri[AW] || rs_ii[AW] || rs_rj[AW] || rs_ij[AW]) begin
					sat_q <= 1'b1;
				end
			end else begin
				acc_q <= acc_q + qsve_pkg::ACC_W'(sqr_s2) + qsve_pkg::ACC_W'(sqi_s2);
			end
		end
		if (out_load) begin
			out_word_q <= res_word;
		end
	end

	qsve_ram #(.WIDTH(qsve_pkg::AMP_W2), .DEPTH(qsve_pkg::BANK_DEPTH)) u_bank0 (
		.clk     (clk),
		.wr_en   (we0),
		.wr_addr (wa0),
		.wr_data (wdat0),
		.rd_en   (issue),
		.rd_addr (ra0),
		.rd_data (rd0)
	);

	qsve_ram #(.WIDTH(qsve_pkg::AMP_W2), .DEPTH(qsve_pkg::BANK_DEPTH)) u_bank1 (
		.clk     (clk),
		.wr_en   (we1),
		.wr_addr (wa1),
		.wr_data (wdat1),
		.rd_en   (issue),
		.rd_addr (ra1),
		.rd_data (rd1)
	);

	assign we0   = clr_we || v_s3;
	assign we1   = clr_we || v_s3;
	assign wa0   = clr_we ? cnt_q : ba0_s3;
	assign wa1   = clr_we ? cnt_q : ba1_s3;
	assign wdat0 = clr_we ? ((cnt_q == '0) ? AMP_ONE : '0) : wd0_s3;
	assign wdat1 = clr_we ? '0 : wd1_s3;

	assign amp_a = swap_s1 ? rd1 : rd0;
	assign amp_b = swap_s1 ? rd0 : rd1;
	assign ar    = $signed(amp_a[2*AW-1:AW]);
	assign ai    = $signed(amp_a[AW-1:0]);
	assign br    = $signed(amp_b[2*AW-1:AW]);
	assign bi    = $signed(amp_b[AW-1:0]);

	assign g[0] = item_q.gate_00_re;
	assign g[1] = item_q.gate_00_im;
	assign g[2] = item_q.gate_01_re;
	assign g[3] = item_q.gate_01_im;
	assign g[4] = item_q.gate_10_re;
	assign g[5] = item_q.gate_10_im;
	assign g[6] = item_q.gate_11_re;
	assign g[7] = item_q.gate_11_im;

	always_ff @(posedge clk) begin
		swap_s1 <= par_i;
		ba0_s1  <= ra0;
		ba1_s1  <= ra1;
		swap_s2 <= swap_s1;
		ba0_s2  <= ba0_s1;
		ba1_s2  <= ba1_s1;
		prod_s2[0]  <= g[0] * ar;
		prod_s2[1]  <= g[1] * ai;
		prod_s2[2]  <= g[2] * br;
		prod_s2[3]  <= g[3] * bi;
		prod_s2[4]  <= g[0] * ai;
		prod_s2[5]  <= g[1] * ar;
		prod_s2[6]  <= g[2] * bi;
		prod_s2[7]  <= g[3] * br;
		prod_s2[8]  <= g[4] * ar;
		prod_s2[9]  <= g[5] * ai;
		prod_s2[10] <= g[6] * br;
		prod_s2[11] <= g[7] * bi;
		prod_s2[12] <= g[4] * ai;
		prod_s2[13] <= g[5] * ar;
		prod_s2[14] <= g[6] * bi;
		prod_s2[15] <= g[7] * br;
		sqr_s2 <= qsve_pkg::PROD_W'(ar * ar);
		sqi_s2 <= qsve_pkg::PROD_W'(ai * ai);
		ba0_s3 <= ba0_s2;
		ba1_s3 <= ba1_s2;
		wd0_s3 <= swap_s2 ? new_j : new_i;
		wd1_s3 <= swap_s2 ? new_i : new_j;
	end

	assign sum_ri = qsve_pkg::SUM_W'(prod_s2[0]) - qsve_pkg::SUM_W'(prod_s2[1])
		+ qsve_pkg::SUM_W'(prod_s2[2]) - qsve_pkg::SUM_W'(prod_s2[3]);
	assign sum_ii = qsve_pkg::SUM_W'(prod_s2[4]) + qsve_pkg::SUM_W'(prod_s2[5])
		+ qsve_pkg::SUM_W'(prod_s2[6]) + qsve_pkg::SUM_W'(prod_s2[7]);
	assign sum_rj = qsve_pkg::SUM_W'(prod_s2[8]) - qsve_pkg::SUM_W'(prod_s2[9])
		+ qsve_pkg::SUM_W'(prod_s2[10]) - qsve_pkg::SUM_W'(prod_s2[11]);
	assign sum_ij = qsve_pkg::SUM_W'(prod_s2[12]) + qsve_pkg::SUM_W'(prod_s2[13])
		+ qsve_pkg::SUM_W'(prod_s2[14]) + qsve_pkg::SUM_W'(prod_s2[15]);

	assign rs_ri = round_sat(sum_ri);
	assign rs_ii = round_sat(sum_ii);
	assign rs_rj = round_sat(sum_rj);
	assign rs_ij = round_sat(sum_ij);
	assign new_i = {rs_ri[AW-1:0], rs_ii[AW-1:0]};
	assign new_j = {rs_rj[AW-1:0], rs_ij[AW-1:0]};

	assign p_val = acc_q[qsve_pkg::ACC_W-1:qsve_pkg::P_SHIFT];

	always_comb begin
		res_word = '0;
		unique case (item_q.operation)
			qsve_pkg::OP_INIT,
			qsve_pkg::OP_NONE: res_word = '0;
			qsve_pkg::OP_GATE: begin
				if (!in_range) begin
					res_word.status = qsve_pkg::ST_RANGE;
				end else if (sat_q) begin
					res_word.status = qsve_pkg::ST_SAT;
				end
			end
			qsve_pkg::OP_MEAS: begin
				if (!in_range) begin
					res_word.status = qsve_pkg::ST_RANGE;
				end else begin
					res_word.outcome =
						!(qsve_pkg::P_W'(item_q.random_fraction) < p_val);
					res_word.probability_zero =
						(p_val > qsve_pkg::P_W'({qsve_pkg::PROB_W{1'b1}})) ?
						{qsve_pkg::PROB_W{1'b1}} : p_val[qsve_pkg::PROB_W-1:0];
				end
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`QSVE_ASSERT(a_no_write_idle, !((state_q == qsve_pkg::S_IDLE) && (we0 || we1)))
	`QSVE_ASSERT_IMPL(a_s3_follows_s2, v_s3, $past(v_s2))
	`QSVE_ASSERT_IMPL(a_cnt_bound, state_q == qsve_pkg::S_RUN, {1'b0, cnt_q} < pairs)
	`QSVE_ASSERT_IMPL(a_out_fell_taken, $fell(out_valid_q), $past(!out_stall))

endmodule

// File: src/qsve_ram.sv
// ----------------------------------------------------------------------------
// qsve_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module qsve_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
